/* rtl/wmap_pkg.sv */
// package for the weighted moving average predictor
// types, widths and register codes shared by all rtl files; no dependencies
package wmap_pkg;

  localparam int DATA_W      = 16;
  localparam int TAP_W       = 3;
  localparam int NUM_WEIGHTS = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int FRAC_BITS   = 14;

  // extra weight: sum of up to five weights, and its magnitude
  localparam int EXT_W  = 19;
  localparam int MAG_W  = 18;
  localparam int COEF_W = 20;
  localparam int PROD_W = DATA_W + COEF_W;
  localparam int ACC_W  = 40;
  localparam int DIV_CNT_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LAST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT     = 3'd7;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic signed [DATA_W-1:0] WEIGHT0_RESET = 16'sd16384;
  localparam logic signed [DATA_W-1:0] SAT_MAX       = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] SAT_MIN       = 16'sh8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIVGO,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_e;

endpackage

/* rtl/wmap_if.sv */
// valid/ready channel interfaces of the predictor: config, sample and result
// depends on wmap_pkg
interface wmap_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [wmap_pkg::CFG_IDX_W-1:0]     index;
  logic [wmap_pkg::DATA_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface wmap_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [wmap_pkg::DATA_W-1:0] sample_value;
  modport source (output valid, cmd, sample_value, input ready);
  modport sink (input valid, cmd, sample_value, output ready);
endinterface

interface wmap_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [wmap_pkg::DATA_W-1:0] prediction;
  logic                               used_default;
  logic                               saturated;
  modport source (output valid, prediction, used_default, saturated, input ready);
  modport sink (input valid, prediction, used_default, saturated, output ready);
endinterface

/* rtl/wmap_div.sv */
// restoring divider, one quotient bit per cycle, for the extra tap weight
// depends on wmap_pkg
module wmap_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wmap_pkg::MAG_W-1:0]    dividend_i,
  input  logic [wmap_pkg::TAP_W-1:0]    divisor_i,
  output logic                          busy_o,
  output logic [wmap_pkg::MAG_W-1:0]    quotient_o
);

  logic                               busy_q;
  logic [wmap_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [wmap_pkg::TAP_W-1:0]         rem_q;
  logic [wmap_pkg::TAP_W-1:0]         rem_d;
  logic [wmap_pkg::TAP_W-1:0]         dvs_q;
  logic [wmap_pkg::MAG_W-1:0]         quo_q;
  logic [wmap_pkg::TAP_W:0]           trial;
  logic                               ge;

  assign trial = {rem_q, quo_q[wmap_pkg::MAG_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  // remainder stays below the divisor, so it fits in tap width
  always_comb begin
    if (ge) begin
      rem_d = wmap_pkg::TAP_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[wmap_pkg::TAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= wmap_pkg::DIV_CNT_W'(wmap_pkg::MAG_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == wmap_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[wmap_pkg::MAG_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/weighted_moving_average_predictor_top.sv */
// weighted moving average predictor, one request at a time on a shared multiplier
// push with full history: a multiply and an accumulate step for each of the n taps;
// while filling, first a sum step for each weight beyond n, then a divider run
// clear: goes straight to the result. next request is taken once the result is registered
// async active-low reset: weights tap0=1.0 others 0, taps 1, default 0, history empty
// depends on wmap_pkg, wmap_if and wmap_div
module weighted_moving_average_predictor_top #(
  parameter int MAX_TAPS = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  wmap_cfg_if.sink         cfg_i,
  wmap_in_if.sink          in_i,
  wmap_out_if.source       out_o
);

  localparam int HistIdxW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam logic [wmap_pkg::TAP_W-1:0] MaxTapsC = wmap_pkg::TAP_W'(MAX_TAPS);

  // configuration
  logic signed [wmap_pkg::DATA_W-1:0] weight_q [wmap_pkg::NUM_WEIGHTS];
  logic [wmap_pkg::TAP_W-1:0]         taps_cfg_q;
  logic signed [wmap_pkg::DATA_W-1:0] default_q;

  // history and sequencer
  logic signed [wmap_pkg::DATA_W-1:0] hist_q [MAX_TAPS];
  logic [wmap_pkg::TAP_W-1:0]         count_q;
  wmap_pkg::state_e                   state_q, state_d;
  logic [wmap_pkg::TAP_W-1:0]         idx_q;
  logic [wmap_pkg::TAP_W-1:0]         n_q;
  logic [wmap_pkg::TAP_W-1:0]         taps_q;
  logic                               clr_q;

  // datapath
  logic signed [wmap_pkg::EXT_W-1:0]  ext_sum_q;
  logic signed [wmap_pkg::EXT_W-1:0]  extra_q;
  logic signed [wmap_pkg::EXT_W-1:0]  quo_s;
  logic signed [wmap_pkg::COEF_W-1:0] coef;
  logic signed [wmap_pkg::PROD_W-1:0] prod_q;
  logic signed [wmap_pkg::ACC_W-1:0]  acc_q;
  logic signed [wmap_pkg::ACC_W-1:0]  q_full;
  logic [wmap_pkg::EXT_W-1:0]         ext_mag;
  logic [wmap_pkg::MAG_W-1:0]         div_quo;
  logic                               div_busy;
  logic                               div_start;

  // request handling
  logic [wmap_pkg::TAP_W-1:0]         taps_eff;
  logic [wmap_pkg::TAP_W-1:0]         count_inc;
  logic [wmap_pkg::TAP_W-1:0]         n_new;
  logic                               in_acc;
  logic                               in_ready;
  logic                               out_free;
  logic                               out_load;
  logic                               sat_hi;
  logic                               sat_lo;

  // output register
  logic                               out_valid_q;
  logic signed [wmap_pkg::DATA_W-1:0] pred_q;
  logic                               used_def_q;
  logic                               sat_q;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign in_acc      = in_i.valid && in_ready;
  assign out_free    = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q[0] <= wmap_pkg::WEIGHT0_RESET;
      for (int i = 1; i < wmap_pkg::NUM_WEIGHTS; i++) begin
        weight_q[i] <= '0;
      end
      taps_cfg_q  <= wmap_pkg::TAP_W'(1);
      default_q   <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        wmap_pkg::REG_TAPS: begin
          taps_cfg_q <= cfg_i.data[wmap_pkg::TAP_W-1:0];
        end
        wmap_pkg::REG_DEFAULT: begin
          default_q <= cfg_i.data;
        end
        default: begin
          if (cfg_i.index <= wmap_pkg::REG_WEIGHT_LAST) begin
            weight_q[cfg_i.index] <= cfg_i.data;
          end
        end
      endcase
    end
  end

  // zero taps acts as one, too many acts as the history depth
  always_comb begin
    if (taps_cfg_q == '0) begin
      taps_eff = wmap_pkg::TAP_W'(1);
    end else if (taps_cfg_q > MaxTapsC) begin
      taps_eff = MaxTapsC;
    end else begin
      taps_eff = taps_cfg_q;
    end
  end

  assign count_inc = (count_q < MaxTapsC) ? count_q + 1'b1 : count_q;
  assign n_new     = (count_inc < taps_eff) ? count_inc : taps_eff;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wmap_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_i.cmd == wmap_pkg::CMD_CLEAR) begin
            state_d = wmap_pkg::ST_FIN;
          end else if (n_new < taps_eff) begin
            state_d = wmap_pkg::ST_SUM;
          end else begin
            state_d = wmap_pkg::ST_MUL;
          end
        end
      end
      wmap_pkg::ST_SUM: begin
        if (idx_q == taps_q - 1'b1) begin
          state_d = wmap_pkg::ST_DIVGO;
        end
      end
      wmap_pkg::ST_DIVGO: state_d = wmap_pkg::ST_DIV;
      wmap_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_d = wmap_pkg::ST_MUL;
        end
      end
      wmap_pkg::ST_MUL: state_d = wmap_pkg::ST_ACC;
      wmap_pkg::ST_ACC: begin
        if (idx_q == n_q - 1'b1) begin
          state_d = wmap_pkg::ST_FIN;
        end else begin
          state_d = wmap_pkg::ST_MUL;
        end
      end
      wmap_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = wmap_pkg::ST_IDLE;
        end
      end
      default: state_d = wmap_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      wmap_pkg::ST_IDLE:  in_ready = 1'b1;
      wmap_pkg::ST_DIVGO: div_start = 1'b1;
      wmap_pkg::ST_FIN:   out_load = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wmap_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        count_q <= (in_i.cmd == wmap_pkg::CMD_CLEAR) ? '0 : count_inc;
      end
    end
  end

  // history beyond the count is never read, so a clear only resets the count
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.cmd == wmap_pkg::CMD_PUSH) begin
      for (int i = MAX_TAPS - 1; i > 0; i--) begin
        hist_q[i] <= hist_q[i-1];
      end
      hist_q[0] <= in_i.sample_value;
    end
  end

  // extra weight is truncated toward zero: divide the magnitude
  assign ext_mag = ext_sum_q[wmap_pkg::EXT_W-1] ? wmap_pkg::EXT_W'(-ext_sum_q)
                                                : wmap_pkg::EXT_W'(ext_sum_q);
  assign quo_s   = signed'({1'b0, div_quo});
  assign coef    = wmap_pkg::COEF_W'(weight_q[idx_q]) + wmap_pkg::COEF_W'(extra_q);

  wmap_div u_wmap_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ext_mag[wmap_pkg::MAG_W-1:0]),
    .divisor_i  (n_q),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i) begin
    case (state_q)
      wmap_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_q     <= (n_new < taps_eff) ? n_new : '0;
          n_q       <= n_new;
          taps_q    <= taps_eff;
          ext_sum_q <= '0;
          extra_q   <= '0;
          acc_q     <= '0;
          clr_q     <= in_i.cmd;
        end
      end
      wmap_pkg::ST_SUM: begin
        ext_sum_q <= ext_sum_q + wmap_pkg::EXT_W'(weight_q[idx_q]);
        idx_q     <= idx_q + 1'b1;
      end
      wmap_pkg::ST_DIV: begin
        if (!div_busy) begin
          extra_q <= ext_sum_q[wmap_pkg::EXT_W-1] ? -quo_s : quo_s;
          idx_q   <= '0;
        end
      end
      wmap_pkg::ST_MUL: begin
        prod_q <= hist_q[idx_q[HistIdxW-1:0]] * coef;
      end
      wmap_pkg::ST_ACC: begin
        acc_q <= acc_q + wmap_pkg::ACC_W'(prod_q);
        idx_q <= idx_q + 1'b1;
      end
      default: begin
        idx_q <= idx_q;
      end
    endcase
  end

  // arithmetic shift floors toward minus infinity
  assign q_full = acc_q >>> wmap_pkg::FRAC_BITS;
  assign sat_hi = q_full > wmap_pkg::ACC_W'(wmap_pkg::SAT_MAX);
  assign sat_lo = q_full < wmap_pkg::ACC_W'(wmap_pkg::SAT_MIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (clr_q) begin
        pred_q     <= default_q;
        used_def_q <= 1'b1;
        sat_q      <= 1'b0;
      end else begin
        used_def_q <= 1'b0;
        sat_q      <= sat_hi || sat_lo;
        if (sat_hi) begin
          pred_q <= wmap_pkg::SAT_MAX;
        end else if (sat_lo) begin
          pred_q <= wmap_pkg::SAT_MIN;
        end else begin
          pred_q <= q_full[wmap_pkg::DATA_W-1:0];
        end
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.prediction   = pred_q;
  assign out_o.used_default = used_def_q;
  assign out_o.saturated    = sat_q;

endmodule

/* rtl/wmap_checker.sv */
// port-level checks of the predictor, bound to the top level
// depends on wmap_pkg and weighted_moving_average_predictor_top
module wmap_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [wmap_pkg::DATA_W-1:0] prediction_i,
  input logic                               used_default_i,
  input logic                               saturated_i
);

  // one request at a time: busy right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input still ready after a request");

  // a default result never comes from the clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(used_default_i && saturated_i))
    else $error("default result flagged as saturated");

  // results only appear once a request has been worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result appeared while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(prediction_i))
    else $error("stalled result changed");

endmodule

bind weighted_moving_average_predictor_top wmap_checker u_wmap_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .prediction_i   (out_o.prediction),
  .used_default_i (out_o.used_default),
  .saturated_i    (out_o.saturated)
);
